// File: rtl/tlq_pkg.sv
`default_nettype none

package tlq_pkg;

	// Field widths of the command and response.
	localparam int QID_W = 4;
	localparam int TID_W = 5;

	// Action codes.
	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_UNLINK = 2'd2
	} action_t;

	// One command as it arrives on the input side.
	typedef struct packed {
		action_t            action;
		logic [QID_W-1:0]   queue_id;
		logic [TID_W-1:0]   task_id;
	} cmd_t;

	// One response as it leaves the block.
	typedef struct packed {
		logic [TID_W-1:0]   head_task;
		logic               queue_empty;
		logic [TID_W-1:0]   removed_task;
		logic               removed_valid;
	} rsp_t;

endpackage

`default_nettype wire

// File: rtl/tlq_in_stage.sv
`default_nettype none

module tlq_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire tlq_pkg::cmd_t cmd,
	output logic               busy,
	output logic               valid_s1,
	output tlq_pkg::cmd_t      cmd_s1
);
	import tlq_pkg::*;

	logic accept;

	// The list update never needs to stall, so a command is never refused.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Command payload, captured on each transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tlq_list_core.sv
`default_nettype none

module tlq_list_core #(
	parameter int TASK_SLOTS  = 32,
	parameter int QUEUE_COUNT = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_s1,
	input  wire tlq_pkg::cmd_t cmd_s1,
	output logic               done,
	output tlq_pkg::rsp_t      rsp
);
	import tlq_pkg::*;

	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

	// Queue heads, non-empty flags and per-slot links.
	logic [SW-1:0]          head_q [QUEUE_COUNT];
	logic [QUEUE_COUNT-1:0] nonempty_q;
	logic [SW-1:0]          next_q [TASK_SLOTS];
	logic [TASK_SLOTS-1:0]  null_q;
	logic [SW-1:0]          back_q [TASK_SLOTS];

	// Write requests produced by the update logic. Port one wins over port zero.
	typedef struct packed {
		logic          head_we;
		logic [SW-1:0] head_wd;
		logic          ne_we;
		logic          ne_wd;
		logic          lk0_we;
		logic [SW-1:0] lk0_a;
		logic [SW-1:0] lk0_next;
		logic          lk0_null;
		logic          lk1_we;
		logic [SW-1:0] lk1_a;
		logic [SW-1:0] lk1_next;
		logic          lk1_null;
		logic          bk0_we;
		logic [SW-1:0] bk0_a;
		logic [SW-1:0] bk0_d;
		logic          bk1_we;
		logic [SW-1:0] bk1_a;
		logic [SW-1:0] bk1_d;
	} wr_t;

	wr_t           wr;
	logic [QW-1:0] qi;
	logic          q_ok;
	logic          t_ok;
	logic [SW-1:0] t;
	logic [SW-1:0] h;
	logic          ne;
	logic [SW-1:0] tail;
	logic          h_null;
	logic [SW-1:0] h_next;
	logic [SW-1:0] t_prev;
	logic [SW-1:0] t_next;
	logic          t_last;
	logic          new_ne;
	logic [SW-1:0] new_head;
	logic [SW-1:0] rem;
	logic          rem_v;

	// Reads of the current list state around the named queue and task.
	assign qi     = QW'(cmd_s1.queue_id);
	assign t      = SW'(cmd_s1.task_id);
	assign q_ok   = 32'(cmd_s1.queue_id) < QUEUE_COUNT;
	assign t_ok   = 32'(cmd_s1.task_id) < TASK_SLOTS;
	assign h      = head_q[qi];
	assign ne     = nonempty_q[qi];
	assign tail   = back_q[h];
	assign h_null = null_q[h];
	assign h_next = next_q[h];
	assign t_prev = back_q[t];
	assign t_next = next_q[t];
	assign t_last = null_q[t];

	// Update logic: decide the link writes and the queue state after the action.
	always_comb begin
		wr       = '0;
		new_ne   = ne;
		new_head = h;
		rem      = '0;
		rem_v    = 1'b0;
		if (valid_s1 && q_ok) begin
			unique case (cmd_s1.action)
				ACT_APPEND: begin
					if (t_ok) begin
						if (!ne) begin
							wr.head_we = 1'b1;
							wr.head_wd = t;
							wr.ne_we   = 1'b1;
							wr.ne_wd   = 1'b1;
							wr.bk0_we  = 1'b1;
							wr.bk0_a   = t;
							wr.bk0_d   = t;
							new_ne     = 1'b1;
							new_head   = t;
						end else begin
							// Old tail points to the new task; head's back link moves on.
							wr.lk0_we   = 1'b1;
							wr.lk0_a    = tail;
							wr.lk0_next = t;
							wr.lk0_null = 1'b0;
							wr.bk0_we   = 1'b1;
							wr.bk0_a    = t;
							wr.bk0_d    = tail;
							wr.bk1_we   = 1'b1;
							wr.bk1_a    = h;
							wr.bk1_d    = t;
						end
						wr.lk1_we   = 1'b1;
						wr.lk1_a    = t;
						wr.lk1_next = '0;
						wr.lk1_null = 1'b1;
					end
				end
				ACT_REMOVE, ACT_UNLINK: begin
					if (ne && (cmd_s1.action == ACT_REMOVE || t_ok)) begin
						rem_v = 1'b1;
						rem   = (cmd_s1.action == ACT_REMOVE) ? h : t;
						if (cmd_s1.action == ACT_REMOVE || h == t) begin
							// Take out the head; the next task inherits the tail pointer.
							if (h_null) begin
								wr.ne_we = 1'b1;
								wr.ne_wd = 1'b0;
								new_ne   = 1'b0;
							end else begin
								wr.head_we = 1'b1;
								wr.head_wd = h_next;
								wr.bk0_we  = 1'b1;
								wr.bk0_a   = h_next;
								wr.bk0_d   = tail;
								new_head   = h_next;
							end
						end else begin
							// Bridge the neighbors of a task inside the list.
							wr.lk0_we   = 1'b1;
							wr.lk0_a    = t_prev;
							wr.lk0_next = t_next;
							wr.lk0_null = t_last;
							wr.bk0_we   = 1'b1;
							wr.bk0_a    = t_last ? h : t_next;
							wr.bk0_d    = t_prev;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (!q_ok) begin
			new_ne = 1'b0;
		end
	end

	// Non-empty flags are the only list state cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
		end else if (wr.ne_we) begin
			nonempty_q[qi] <= wr.ne_wd;
		end
	end

	// Head and link stores; later ports override earlier ones on the same slot.
	always_ff @(posedge clk) begin
		if (wr.head_we) begin
			head_q[qi] <= wr.head_wd;
		end
		if (wr.lk0_we) begin
			next_q[wr.lk0_a] <= wr.lk0_next;
			null_q[wr.lk0_a] <= wr.lk0_null;
		end
		if (wr.lk1_we) begin
			next_q[wr.lk1_a] <= wr.lk1_next;
			null_q[wr.lk1_a] <= wr.lk1_null;
		end
		if (wr.bk0_we) begin
			back_q[wr.bk0_a] <= wr.bk0_d;
		end
		if (wr.bk1_we) begin
			back_q[wr.bk1_a] <= wr.bk1_d;
		end
	end

	// Response strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp.head_task     <= new_ne ? TID_W'(new_head) : '0;
			rsp.queue_empty   <= ~new_ne;
			rsp.removed_task  <= TID_W'(rem);
			rsp.removed_valid <= rem_v;
		end
	end

endmodule

`default_nettype wire

// File: rtl/task_link_queue.sv
`default_nettype none

// Task link queue: QUEUE_COUNT queues kept as doubly linked lists over a shared
// pool of TASK_SLOTS task slots. A command (append at tail, remove head, unlink
// a named task) is taken at each rising edge where start is high and busy is
// low; busy stays low, so one command can be issued every cycle. The response
// leaves the response register, which follows the command register, marked by
// a one-cycle done pulse, and must be captured in that cycle because the
// receiver cannot stall the block. Responses come out in command order. The list
// update reads and rewrites the flip-flop link stores for each command, so a
// command always sees the effect of the one before it.
module task_link_queue #(
	parameter int TASK_SLOTS  = 32,
	parameter int QUEUE_COUNT = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire tlq_pkg::cmd_t cmd,
	output logic               done,
	output tlq_pkg::rsp_t      rsp
);
	import tlq_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;

	// Command register.
	tlq_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1)
	);

	// List stores, update logic and response register.
	tlq_list_core #(
		.TASK_SLOTS  (TASK_SLOTS),
		.QUEUE_COUNT (QUEUE_COUNT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// File: rtl/tlq_checker.sv
`default_nettype none

module tlq_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire tlq_pkg::cmd_t cmd,
	input wire logic          done,
	input wire tlq_pkg::rsp_t rsp
);
	import tlq_pkg::*;

	// Every transfer yields a response, through the command and response registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("command transfer without response");

	// No response appears without a matching earlier transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("response without command transfer");

	// An empty queue reports slot zero as its head.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.queue_empty) |-> (rsp.head_task == '0))
		else $error("empty queue with nonzero head");

	// A response that removed nothing reports slot zero as removed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.removed_valid) |-> (rsp.removed_task == '0))
		else $error("removed slot set without removal");

endmodule

bind task_link_queue tlq_checker u_chk (.*);

`default_nettype wire

// File: tb/task_link_queue_tb.sv
`timescale 1ns / 1ps

module task_link_queue_tb;

	import tlq_pkg::*;

	localparam int TASK_SLOTS  = 32;
	localparam int QUEUE_COUNT = 16;
	localparam int STALL_LIMIT = 500;
	localparam int SETTLE_CYCLES = 10;

	// The one action code that the package leaves unnamed.
	localparam action_t ACT_RESERVED = action_t'(2'b11);

	logic  clk;
	logic  arst_n = 1'b0;
	logic  start  = 1'b0;
	cmd_t  cmd    = '0;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	task_link_queue #(
		.TASK_SLOTS (TASK_SLOTS),
		.QUEUE_COUNT(QUEUE_COUNT)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.rsp   (rsp)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mirror of the list state: queue heads and flags, per-slot links.
	logic [TID_W-1:0] q_first   [QUEUE_COUNT];
	bit               q_busy    [QUEUE_COUNT];
	logic [TID_W-1:0] next_of   [TASK_SLOTS];
	bit               next_null [TASK_SLOTS];
	logic [TID_W-1:0] back_of   [TASK_SLOTS];

	// Which queue each slot sits in (-1 when free), used to build legal traffic.
	int owner    [TASK_SLOTS];
	bit appended [TASK_SLOTS];

	rsp_t pending_rsp[$];

	int idle_pct = 0;
	int n_errors = 0;
	int n_results = 0;
	int n_appends = 0;
	int n_removes = 0;
	int n_unlinks = 0;
	int n_reserved = 0;
	int n_taken = 0;
	int max_depth = 0;
	int stall_cycles = 0;

	initial begin
		for (int i = 0; i < QUEUE_COUNT; i++) begin
			q_first[i] = '0;
			q_busy[i] = 1'b0;
		end
		for (int i = 0; i < TASK_SLOTS; i++) begin
			next_of[i] = '0;
			next_null[i] = 1'b0;
			back_of[i] = '0;
			owner[i] = -1;
			appended[i] = 1'b0;
		end
	end

	task automatic report_mismatch(input string msg);
		n_errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Take the head off queue q; the head's back link moves to the new head.
	function automatic void drop_head(input int q);
		logic [TID_W-1:0] top;
		logic [TID_W-1:0] nh;
		top = q_first[q];
		if (next_null[top]) begin
			q_busy[q] = 1'b0;
		end else begin
			nh = next_of[top];
			q_first[q] = nh;
			back_of[nh] = back_of[top];
		end
	endfunction

	// Apply one command to the mirrored lists and return the response it must give.
	function automatic rsp_t update_lists(input cmd_t c);
		int               q;
		logic [TID_W-1:0] t;
		logic [TID_W-1:0] h;
		logic [TID_W-1:0] tail;
		logic [TID_W-1:0] prev;
		logic [TID_W-1:0] nxt;
		bit               was_tail;
		rsp_t             r;
		q = c.queue_id;
		t = c.task_id;
		r = '0;
		case (c.action)
			ACT_APPEND: begin
				if (!q_busy[q]) begin
					q_first[q] = t;
					q_busy[q] = 1'b1;
					back_of[t] = t;
				end else begin
					h = q_first[q];
					tail = back_of[h];
					next_of[tail] = t;
					next_null[tail] = 1'b0;
					back_of[t] = tail;
					back_of[h] = t;
				end
				next_null[t] = 1'b1;
				next_of[t] = '0;
			end
			ACT_REMOVE: begin
				if (q_busy[q]) begin
					r.removed_task = q_first[q];
					r.removed_valid = 1'b1;
					drop_head(q);
				end
			end
			ACT_UNLINK: begin
				if (q_busy[q]) begin
					h = q_first[q];
					r.removed_task = t;
					r.removed_valid = 1'b1;
					if (h == t) begin
						drop_head(q);
					end else begin
						prev = back_of[t];
						nxt = next_of[t];
						was_tail = next_null[t];
						next_of[prev] = nxt;
						next_null[prev] = was_tail;
						if (!was_tail)
							back_of[nxt] = prev;
						else
							back_of[h] = prev;
					end
				end
			end
			default: begin
			end
		endcase
		if (q_busy[q]) begin
			r.head_task = q_first[q];
			r.queue_empty = 1'b0;
		end else begin
			r.head_task = '0;
			r.queue_empty = 1'b1;
		end
		return r;
	endfunction

	// Issue one command, wait for its transfer, and queue up the expected response.
	task automatic send_cmd(input action_t act, input int qid, input int tid);
		cmd_t c;
		rsp_t r;
		int   depth;
		c.action = act;
		c.queue_id = qid[QID_W-1:0];
		c.task_id = tid[TID_W-1:0];
		// Each cycle the sender stays idle with the chosen probability.
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = update_lists(c);
		pending_rsp.push_back(r);
		case (act)
			ACT_APPEND: n_appends++;
			ACT_REMOVE: n_removes++;
			ACT_UNLINK: n_unlinks++;
			default: n_reserved++;
		endcase
		// Keep slot ownership in step for the traffic generator.
		if (act == ACT_APPEND) begin
			owner[c.task_id] = c.queue_id;
			appended[c.task_id] = 1'b1;
		end
		if (r.removed_valid) begin
			owner[r.removed_task] = -1;
			n_taken++;
		end
		depth = 0;
		for (int i = 0; i < TASK_SLOTS; i++)
			if (owner[i] == c.queue_id)
				depth++;
		if (depth > max_depth)
			max_depth = depth;
	endtask

	// Hold off new commands until every outstanding response has come back.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// Random slot that is queued (want_queued) or free; -1 when there is none.
	function automatic int pick_task(input bit want_queued);
		int n;
		int k;
		n = 0;
		for (int i = 0; i < TASK_SLOTS; i++)
			if ((owner[i] >= 0) == want_queued)
				n++;
		if (n == 0)
			return -1;
		k = $urandom_range(0, n - 1);
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if ((owner[i] >= 0) == want_queued) begin
				if (k == 0)
					return i;
				k--;
			end
		end
		return -1;
	endfunction

	// Most traffic goes to a few queues so that the lists grow long.
	function automatic int pick_queue();
		if ($urandom_range(0, 99) < 60)
			return $urandom_range(0, 3);
		return $urandom_range(0, QUEUE_COUNT - 1);
	endfunction

	// Response checker: each strobed response is matched against the oldest expectation.
	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && done) begin
			n_results++;
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("response with no command outstanding (head %0d)",
					rsp.head_task));
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.head_task !== want.head_task)
					report_mismatch($sformatf("head_task got %0d expected %0d",
						rsp.head_task, want.head_task));
				if (rsp.queue_empty !== want.queue_empty)
					report_mismatch($sformatf("queue_empty got %0b expected %0b",
						rsp.queue_empty, want.queue_empty));
				if (rsp.removed_task !== want.removed_task)
					report_mismatch($sformatf("removed_task got %0d expected %0d",
						rsp.removed_task, want.removed_task));
				if (rsp.removed_valid !== want.removed_valid)
					report_mismatch($sformatf("removed_valid got %0b expected %0b",
						rsp.removed_valid, want.removed_valid));
			end
		end
	end

	// Watchdog: ends the run when neither a transfer nor a response happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer or response for %0d cycles", STALL_LIMIT);
			$display("task_link_queue test failed");
			$finish;
		end
	end

	// Hand-picked sequence: empty-queue cases, the reserved code, and every unlink position.
	task automatic test_directed();
		send_cmd(ACT_REMOVE, 0, 31);
		send_cmd(ACT_UNLINK, 15, 31);
		send_cmd(ACT_RESERVED, 3, 0);
		send_cmd(ACT_APPEND, 0, 0);
		send_cmd(ACT_APPEND, 0, 31);
		send_cmd(ACT_APPEND, 0, 5);
		send_cmd(ACT_APPEND, 15, 17);
		send_cmd(ACT_RESERVED, 0, 31);
		send_cmd(ACT_UNLINK, 0, 31);
		send_cmd(ACT_UNLINK, 0, 5);
		send_cmd(ACT_APPEND, 0, 10);
		send_cmd(ACT_APPEND, 0, 20);
		send_cmd(ACT_UNLINK, 0, 0);
		send_cmd(ACT_REMOVE, 0, 0);
		send_cmd(ACT_REMOVE, 0, 7);
		send_cmd(ACT_REMOVE, 0, 7);
		send_cmd(ACT_UNLINK, 15, 17);
		send_cmd(ACT_APPEND, 15, 31);
		send_cmd(ACT_REMOVE, 15, 0);
	endtask

	// Legal list traffic with random content, plus a share of commands that change nothing.
	task automatic test_random_traffic(input int count, input int idle);
		int roll;
		int t;
		int q;
		idle_pct = idle;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				t = pick_task(1'b0);
				if (t >= 0) begin
					send_cmd(ACT_APPEND, pick_queue(), t);
				end else begin
					t = pick_task(1'b1);
					send_cmd(ACT_UNLINK, owner[t], t);
				end
			end else if (roll < 70) begin
				send_cmd(ACT_REMOVE, pick_queue(), $urandom_range(0, TASK_SLOTS - 1));
			end else if (roll < 92) begin
				t = pick_task(1'b1);
				if (t >= 0)
					send_cmd(ACT_UNLINK, owner[t], t);
				else
					send_cmd(ACT_APPEND, pick_queue(), pick_task(1'b0));
			end else begin
				q = $urandom_range(0, QUEUE_COUNT - 1);
				if ($urandom_range(0, 1) == 0 && !q_busy[q])
					send_cmd(ACT_UNLINK, q, $urandom_range(0, TASK_SLOTS - 1));
				else
					send_cmd(ACT_RESERVED, q, $urandom_range(0, TASK_SLOTS - 1));
			end
		end
		idle_pct = 0;
	endtask

	// Duplicate appends and unlinks from the wrong queue. Every slot gets appended
	// first, so that no link entry is read before it has been written.
	task automatic test_list_misuse();
		int t;
		int u;
		int q;
		for (int i = 0; i < TASK_SLOTS; i++)
			if (!appended[i])
				send_cmd(ACT_APPEND, pick_queue(), i);
		t = pick_task(1'b1);
		if (t >= 0) begin
			q = (owner[t] + 1) % QUEUE_COUNT;
			send_cmd(ACT_APPEND, q, t);
			u = (t + 1) % TASK_SLOTS;
			send_cmd(ACT_UNLINK, q, u);
		end
		for (int n = 0; n < 40; n++)
			send_cmd(action_t'($urandom_range(0, 3)), $urandom_range(0, QUEUE_COUNT - 1),
				$urandom_range(0, TASK_SLOTS - 1));
	endtask

	// Test sequence.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_random_traffic(340, 15);
		wait_drained();
		test_random_traffic(340, 78);
		wait_drained();
		test_random_traffic(320, 0);
		wait_drained();
		test_list_misuse();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d appends, %0d head removals, %0d unlinks and %0d reserved commands;",
			n_appends, n_removes, n_unlinks, n_reserved);
		$display("%0d responses checked, %0d tasks taken out, longest queue %0d tasks.",
			n_results, n_taken, max_depth);
		if (n_errors == 0)
			$display("task_link_queue test passed");
		else
			$display("task_link_queue test failed");
		$finish;
	end

endmodule
